// ===== sv/bltre_pkg.sv =====
// Package for the bintree triangle emitter: command and sequencer codes,
// enable map geometry and the request word to the map store.
// Used by bltre_map, bintree_lod_triangle_emitter, bltre_checker and the testbench.
package bltre_pkg;

  localparam int unsigned MapWords   = 256;
  localparam int unsigned MapAddrW   = 8;
  localparam int unsigned MapDataW   = 64;
  localparam int unsigned BitSelW    = 6;
  localparam int unsigned MapCoordW  = 7;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned StackIdxW  = 4;
  localparam int unsigned LevelW     = 5;
  localparam int unsigned CountW     = 16;
  localparam int unsigned OutCoordW  = 8;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_DECIDE = 1'b1
  } state_e;

  typedef struct packed {
    logic                we;
    logic [MapAddrW-1:0] waddr;
    logic [MapDataW-1:0] wdata;
    logic [MapAddrW-1:0] raddr;
    logic                re;
  } map_req_t;

endpackage

// ===== sv/bltre_map.sv =====
// Enable bitmap store: 256 words of 64 bits, one write per cycle and a
// registered read that holds until the next read request, with a valid bit
// per word so unwritten words read with the valid bit low. Depends on bltre_pkg.
module bltre_map
  import bltre_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  map_req_t            req_i,
  output logic [MapDataW-1:0] rd_word_o,
  output logic                rd_valid_o
);

  logic [MapDataW-1:0] mem_q [MapWords];
  logic [MapWords-1:0] vld_q;
  logic [MapDataW-1:0] rd_word_q;
  logic                rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    // hold the read word until the next request
    if (req_i.re) begin
      rd_word_q  <= mem_q[req_i.raddr];
      rd_valid_q <= vld_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.waddr] <= 1'b1;
    end
  end

  assign rd_word_o  = rd_word_q;
  assign rd_valid_o = rd_valid_q;

endmodule

// ===== sv/bintree_lod_triangle_emitter.sv =====
// Bintree LOD triangle emitter top level: command decode, triangle stack,
// two-state sequencer around one midpoint/compare unit, output register.
// Depends on bltre_pkg and bltre_map.
//
//   channel   direction   handshake                 payload
//   input     in          in_valid_i / in_ready_o   cmd, row, word_index, word_data
//   result    out         out_valid_o / out_ready_i a/b/c coords, last, emitted_count
//
// Write, start and unknown commands are taken in idle; a tick on a non-empty
// stack does the pop and enable-map read in idle, then the split or emit in decide.
// The enable map's registered read port is why a tick needs the decide state.
// An emitting tick waits in decide while the output word is full and not taken.
// Reset clears the map valid bits, stack level, count, output valid and sequencer at once.
module bintree_lod_triangle_emitter
  import bltre_pkg::*;
#(
  parameter int unsigned GRID_BITS = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           cmd_i,
  input  logic [6:0]           row_i,
  input  logic                 word_index_i,
  input  logic [63:0]          word_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutCoordW-1:0] a_x_o,
  output logic [OutCoordW-1:0] a_y_o,
  output logic [OutCoordW-1:0] b_x_o,
  output logic [OutCoordW-1:0] b_y_o,
  output logic [OutCoordW-1:0] c_x_o,
  output logic [OutCoordW-1:0] c_y_o,
  output logic                 last_o,
  output logic [CountW-1:0]    emitted_count_o
);

  localparam int unsigned CW = GRID_BITS + 1;
  localparam logic [CW-1:0] GridW    = {1'b1, {GRID_BITS{1'b0}}};
  localparam logic [CW-1:0] GridMask = {1'b0, {GRID_BITS{1'b1}}};
  localparam logic [LevelW-1:0] SplitMax = LevelW'(StackDepth - 2);

  typedef struct packed {
    logic [CW-1:0] ax, ay, bx, by, cx, cy;
  } tri_t;

  typedef struct packed {
    logic in_ready;
    logic pop;
    logic push;
    logic load_out;
  } ctrl_t;

  state_e state_q, state_d;
  ctrl_t  ctrl;

  tri_t              stack_q [StackDepth];
  logic [LevelW-1:0] level_q, level_d;
  logic [CountW-1:0] total_q, total_d;

  tri_t               tri_q;
  logic [CW-1:0]      dx_q, dy_q;
  logic               even_q;
  logic [BitSelW-1:0] bsel_q;

  logic               acc;
  logic               is_write, is_start, is_tick;
  tri_t               top;
  logic [CW:0]        sum_x, sum_y;
  logic [CW-1:0]      dx, dy;
  logic [MapCoordW-1:0] ex, ey;
  map_req_t           map_req;
  logic [MapDataW-1:0] rd_word;
  logic               rd_valid;
  logic               split;

  logic               out_valid_q;
  tri_t               out_tri_q;
  logic               out_last_q;
  logic [CountW-1:0]  out_cnt_q;

  assign acc      = in_valid_i && in_ready_o;
  assign is_write = cmd_i == CMD_WRITE;
  assign is_start = cmd_i == CMD_START;
  assign is_tick  = cmd_i == CMD_TICK;

  // midpoint of the hypotenuse of the stack top
  assign top   = stack_q[StackIdxW'(level_q - LevelW'(1))];
  assign sum_x = {1'b0, top.ax} + {1'b0, top.cx};
  assign sum_y = {1'b0, top.ay} + {1'b0, top.cy};
  assign dx    = sum_x[CW:1];
  assign dy    = sum_y[CW:1];
  assign ex    = MapCoordW'(dx & GridMask);
  assign ey    = MapCoordW'(dy & GridMask);

  always_comb begin
    map_req.we    = acc && is_write;
    map_req.waddr = {row_i, word_index_i};
    map_req.wdata = word_data_i;
    map_req.raddr = {ey, ex[MapCoordW-1]};
    // read only on the pop so the word holds through a stalled decide
    map_req.re    = ctrl.pop;
  end

  bltre_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (map_req),
    .rd_word_o  (rd_word),
    .rd_valid_o (rd_valid)
  );

  assign split = even_q && rd_valid && rd_word[bsel_q] && (level_q <= SplitMax);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && is_tick && (level_q != '0)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (split || !out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.pop      = acc && is_tick && (level_q != '0);
      end
      ST_DECIDE: begin
        ctrl.push     = split;
        ctrl.load_out = !split && (!out_valid_q || out_ready_i);
      end
      default: ctrl = '0;
    endcase
  end

  assign in_ready_o = ctrl.in_ready;

  always_comb begin
    level_d = level_q;
    total_d = total_q;
    if (acc && is_start) begin
      level_d = LevelW'(2);
      total_d = '0;
    end else if (ctrl.pop) begin
      level_d = level_q - LevelW'(1);
    end else if (ctrl.push) begin
      level_d = level_q + LevelW'(2);
    end else if (ctrl.load_out) begin
      total_d = total_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      level_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      total_q <= total_d;
      if (ctrl.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stack entries, per-tick working registers and output word registers
  always_ff @(posedge clk_i) begin
    if (acc && is_start) begin
      stack_q[0] <= '{ax: GridW, ay: '0, bx: GridW, by: GridW, cx: '0, cy: GridW};
      stack_q[1] <= '{ax: '0, ay: GridW, bx: '0, by: '0, cx: GridW, cy: '0};
    end else if (ctrl.push) begin
      stack_q[StackIdxW'(level_q)] <=
        '{ax: tri_q.cx, ay: tri_q.cy, bx: dx_q, by: dy_q, cx: tri_q.bx, cy: tri_q.by};
      stack_q[StackIdxW'(level_q + LevelW'(1))] <=
        '{ax: tri_q.bx, ay: tri_q.by, bx: dx_q, by: dy_q, cx: tri_q.ax, cy: tri_q.ay};
    end
    if (ctrl.pop) begin
      tri_q  <= top;
      dx_q   <= dx;
      dy_q   <= dy;
      even_q <= !(dx[0] || dy[0]);
      bsel_q <= ex[BitSelW-1:0];
    end
    if (ctrl.load_out) begin
      out_tri_q  <= tri_q;
      out_last_q <= level_q == '0;
      out_cnt_q  <= total_q + CountW'(1);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign a_x_o           = OutCoordW'(out_tri_q.ax);
  assign a_y_o           = OutCoordW'(out_tri_q.ay);
  assign b_x_o           = OutCoordW'(out_tri_q.bx);
  assign b_y_o           = OutCoordW'(out_tri_q.by);
  assign c_x_o           = OutCoordW'(out_tri_q.cx);
  assign c_y_o           = OutCoordW'(out_tri_q.cy);
  assign last_o          = out_last_q;
  assign emitted_count_o = out_cnt_q;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LevelW'(StackDepth))
    else $error("stack level beyond depth");

  a_tick_decides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |=> (state_q == ST_DECIDE) && (level_q == $past(level_q) - LevelW'(1)))
    else $error("tick pop did not enter decide");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |=> (level_q == $past(level_q) + LevelW'(2)) && (state_q == ST_IDLE))
    else $error("push did not add two entries");

  a_emit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_out |=> out_valid_q && (out_cnt_q == total_q))
    else $error("emitted count out of step");

  a_no_lost_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten");

endmodule

// ===== bench/bltre_checker.sv =====
// Checker for the bintree LOD triangle emitter: keeps its own enable map and
// triangle stack, predicts each emitted triangle and compares it on the result channel.
// Depends on bltre_pkg for map geometry, stack depth and command codes.
module bltre_checker
  import bltre_pkg::*;
#(
  parameter int unsigned GRID_BITS = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [1:0]           cmd_i,
  input  logic [6:0]           row_i,
  input  logic                 word_index_i,
  input  logic [63:0]          word_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [OutCoordW-1:0] a_x_i,
  input  logic [OutCoordW-1:0] a_y_i,
  input  logic [OutCoordW-1:0] b_x_i,
  input  logic [OutCoordW-1:0] b_y_i,
  input  logic [OutCoordW-1:0] c_x_i,
  input  logic [OutCoordW-1:0] c_y_i,
  input  logic                 last_i,
  input  logic [CountW-1:0]    emitted_count_i,
  output int unsigned          fail_cnt_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] ax, ay, bx, by, cx, cy;
  } tri_t;

  typedef struct packed {
    logic [OutCoordW-1:0] ax, ay, bx, by, cx, cy;
    logic                 last;
    logic [CountW-1:0]    count;
  } emitted_tri_t;

  localparam logic [15:0] GridSize = 16'(32'd1 << GRID_BITS);
  localparam logic [15:0] GridMask = GridSize - 16'd1;

  logic [MapDataW-1:0] enable_words [MapWords];
  tri_t                tri_stack [StackDepth];
  int unsigned         stack_fill;
  logic [CountW-1:0]   emit_total;
  emitted_tri_t        expected_tris [$];

  // Wrap the midpoint by the grid mask, then onto the 128x128 bitmap.
  function automatic logic split_enabled(input logic [15:0] x, input logic [15:0] y);
    logic [15:0] ex;
    logic [15:0] ey;
    ex = x & GridMask & 16'd127;
    ey = y & GridMask & 16'd127;
    return enable_words[{ey[6:0], ex[6]}][ex[5:0]];
  endfunction

  task automatic predict_triangle_step(input logic [1:0] cmd, input logic [6:0] row,
                                       input logic wi, input logic [63:0] data);
    tri_t         t;
    logic [15:0]  dx;
    logic [15:0]  dy;
    emitted_tri_t e;
    case (cmd)
      CMD_WRITE: begin
        enable_words[{row, wi}] = data;
      end
      CMD_START: begin
        tri_stack[0] = '{ax: GridSize, ay: 16'd0, bx: GridSize, by: GridSize,
                         cx: 16'd0, cy: GridSize};
        tri_stack[1] = '{ax: 16'd0, ay: GridSize, bx: 16'd0, by: 16'd0,
                         cx: GridSize, cy: 16'd0};
        stack_fill = 2;
        emit_total = '0;
      end
      CMD_TICK: begin
        if (stack_fill != 0) begin
          stack_fill--;
          t  = tri_stack[stack_fill];
          dx = (t.ax + t.cx) >> 1;
          dy = (t.ay + t.cy) >> 1;
          if (((dx | dy) & 16'd1) == 16'd0 && split_enabled(dx, dy) &&
              stack_fill + 2 <= StackDepth) begin
            // push so that (b, d, a) is popped first
            tri_stack[stack_fill]     = '{ax: t.cx, ay: t.cy, bx: dx, by: dy,
                                          cx: t.bx, cy: t.by};
            tri_stack[stack_fill + 1] = '{ax: t.bx, ay: t.by, bx: dx, by: dy,
                                          cx: t.ax, cy: t.ay};
            stack_fill += 2;
          end else begin
            emit_total++;
            e = '{ax: t.ax[7:0], ay: t.ay[7:0], bx: t.bx[7:0], by: t.by[7:0],
                  cx: t.cx[7:0], cy: t.cy[7:0], last: (stack_fill == 0),
                  count: emit_total};
            expected_tris.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      fail_cnt_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    emitted_tri_t want;
    if (!rst_ni) begin
      foreach (enable_words[i]) enable_words[i] = '0;
      stack_fill = 0;
      emit_total = '0;
      expected_tris.delete();
      fail_cnt_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        predict_triangle_step(cmd_i, row_i, word_index_i, word_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_tris.size() == 0) begin
          fail_cnt_o++;
          $display("%0t: unexpected triangle, expected none, actual count %0d",
                   $time, emitted_count_i);
        end else begin
          want = expected_tris.pop_front();
          check_field("a_x", 16'(want.ax), 16'(a_x_i));
          check_field("a_y", 16'(want.ay), 16'(a_y_i));
          check_field("b_x", 16'(want.bx), 16'(b_x_i));
          check_field("b_y", 16'(want.by), 16'(b_y_i));
          check_field("c_x", 16'(want.cx), 16'(c_x_i));
          check_field("c_y", 16'(want.cy), 16'(c_y_i));
          check_field("last", 16'(want.last), 16'(last_i));
          check_field("emitted_count", want.count, emitted_count_i);
        end
      end
    end
    pending_o = expected_tris.size();
  end

endmodule

// ===== bench/tb_bintree_lod_triangle_emitter.sv =====
// Testbench top for the bintree LOD triangle emitter: clock, reset, command
// stimulus with random gaps and result back-pressure, watchdog and verdict.
// Depends on bltre_pkg, the emitter RTL and bltre_checker.
module tb_bintree_lod_triangle_emitter
  import bltre_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CmdNone       = 2'd3;
  localparam int unsigned ItemsTarget   = 700;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 20;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           cmd;
  logic [6:0]           row;
  logic                 word_index;
  logic [63:0]          word_data;
  logic                 out_valid;
  logic                 out_ready;
  logic [OutCoordW-1:0] a_x, a_y, b_x, b_y, c_x, c_y;
  logic                 last;
  logic [CountW-1:0]    emitted_count;
  int unsigned          fail_cnt;
  int unsigned          pending;

  int unsigned sent_items;
  int unsigned gap_rate;
  int unsigned stall_rate;
  bit          quiet;
  int unsigned idle_cycles = 0;

  bintree_lod_triangle_emitter u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .row_i          (row),
    .word_index_i   (word_index),
    .word_data_i    (word_data),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .a_x_o          (a_x),
    .a_y_o          (a_y),
    .b_x_o          (b_x),
    .b_y_o          (b_y),
    .c_x_o          (c_x),
    .c_y_o          (c_y),
    .last_o         (last),
    .emitted_count_o(emitted_count)
  );

  bltre_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .cmd_i          (cmd),
    .row_i          (row),
    .word_index_i   (word_index),
    .word_data_i    (word_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .a_x_i          (a_x),
    .a_y_i          (a_y),
    .b_x_i          (b_x),
    .b_y_i          (b_y),
    .c_x_i          (c_x),
    .c_y_i          (c_y),
    .last_i         (last),
    .emitted_count_i(emitted_count),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] random_enables();
    logic [63:0] a;
    logic [63:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0:       return '1;
      1:       return '0;
      2:       return a & b;
      3:       return a | b;
      default: return a;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [1:0] c, input logic [6:0] r, input logic wi,
                           input logic [63:0] data);
    if (!quiet && gap_rate != 0 && $urandom_range(0, 15) < gap_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    row        <= r;
    word_index <= wi;
    word_data  <= data;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (c != CmdNone) sent_items++;
  endtask

  task automatic send_tick();
    send_word(CMD_TICK, 7'($urandom), 1'($urandom), {$urandom, $urandom});
  endtask

  task automatic send_start();
    send_word(CMD_START, 7'($urandom), 1'($urandom), {$urandom, $urandom});
  endtask

  // Hold the sender until every expected triangle has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Result-side back-pressure in random bursts.
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (!quiet && stall_rate != 0 && $urandom_range(0, 15) < stall_rate) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb_bintree_lod_triangle_emitter NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned episode;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    cmd         = CMD_WRITE;
    row         = '0;
    word_index  = 1'b0;
    word_data   = '0;
    sent_items  = 0;
    gap_rate    = 0;
    stall_rate  = 0;
    quiet       = 1'b0;
    episode     = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty-stack tick, unknown command, edge words, restart mid-traversal
    send_tick();
    send_word(CmdNone, 7'($urandom), 1'($urandom), {$urandom, $urandom});
    send_word(CMD_WRITE, 7'd64, 1'b1, '1);
    send_word(CMD_WRITE, 7'd64, 1'b0, '1);
    send_word(CMD_WRITE, 7'd0, 1'b0, '1);
    send_word(CMD_WRITE, 7'd127, 1'b1, '1);
    send_word(CMD_WRITE, 7'd0, 1'b1, '0);
    send_start();
    repeat (10) send_tick();
    send_start();
    repeat (4) send_tick();

    // mostly enabled map so traversals run deep enough to fill the stack
    gap_rate   = 2;
    stall_rate = 2;
    for (int r = 0; r < 128; r++) begin
      for (int w = 0; w < 2; w++) begin
        send_word(CMD_WRITE, 7'(r), 1'(w),
                  ($urandom_range(0, 3) != 0) ? '1 : random_enables());
      end
    end
    send_start();
    repeat (150) send_tick();
    drain_results();

    while (sent_items < ItemsTarget) begin
      if (sent_items + 80 >= ItemsTarget) quiet = 1'b1;
      case ($urandom_range(0, 2))
        0:       gap_rate = 0;
        1:       gap_rate = 2;
        default: gap_rate = 6;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_rate = 0;
        1:       stall_rate = 2;
        default: stall_rate = 6;
      endcase
      repeat ($urandom_range(0, 5)) begin
        send_word(CMD_WRITE, 7'($urandom), 1'($urandom), random_enables());
      end
      if ($urandom_range(0, 7) != 0) send_start();
      repeat ($urandom_range(4, 60)) begin
        if ($urandom_range(0, 19) == 0) begin
          send_word(CmdNone, 7'($urandom), 1'($urandom), {$urandom, $urandom});
        end else begin
          send_tick();
        end
      end
      episode++;
      if (episode % 6 == 3) drain_results();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_bintree_lod_triangle_emitter OK");
    end else begin
      $display("tb_bintree_lod_triangle_emitter NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bltre_pkg.sv
sv/bltre_map.sv
sv/bintree_lod_triangle_emitter.sv
bench/bltre_checker.sv
bench/tb_bintree_lod_triangle_emitter.sv
